### src/btk_pkg.sv
package btk_pkg;
	localparam int ID_W = 48;
	localparam int KEY_W = 32;
	localparam int KC_W = 5;
	localparam int PADDR_W = 1;
	localparam logic [PADDR_W-1:0] REG_KEEP_COUNT = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_SORT_WR,
		ST_DN_CMP,
		ST_DN_CHK,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_OUT_RD,
		ST_OUT_EMIT,
		ST_ROOT_RD,
		ST_ROOT_CMP
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} entry_t;
endpackage

### src/btk_heap_mem.sv
module btk_heap_mem import btk_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output entry_t        rdata_a,
	output entry_t        rdata_b
);
	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

### src/bounded_topk_min_selector_unit.sv
// Bounded top-k selector: keeps the keep_count candidates with the smallest
// distance in a max-heap held in a 2-read/1-write synchronous memory (heap
// positions 1..HEAP_DEPTH stored at addresses 0..HEAP_DEPTH-1). One FSM walks
// the heap a level at a time: each level is a memory read state followed by
// a compare and write-back state. busy is low only in the idle state, in
// which the next word is taken. An insert into a non-full heap lifts the
// candidate level by level through read and compare states. On a full heap
// the root is read and compared first, and a rejected word ends there; a
// replacement then sinks level by level through check and compare states
// and ends either at a leaf or on a compare. busy stays high while a word
// is in work. On a word flagged last_candidate, after the word is handled
// the kept entries are exchange-sorted (a read and a compare state per
// compared pair, n*(n-1)/2 pairs, a write state per swap, and a read-state
// pass per outer index) and then streamed out one result word per read
// and emit state pair, each valid for one cycle with result_valid high;
// the receiver cannot stall and must take every result word.
// The user must write keep_count via APB only while busy is low; the block
// itself does not enforce it.
module bounded_topk_min_selector_unit import btk_pkg::*; #(
	parameter int HEAP_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [ID_W-1:0]     tuple_id,
	input  logic [KEY_W-1:0]    distance,
	input  logic                last_candidate,
	output logic                result_valid,
	output logic [ID_W-1:0]     result_tuple_id,
	output logic [KEY_W-1:0]    result_distance,
	output logic                last_result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W+1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	// position counters hold 1..HEAP_DEPTH and 2*pos+1
	localparam int PW = $clog2(2 * HEAP_DEPTH + 2);

	state_t state_q, state_d;
	logic [KC_W-1:0] keep_q;
	logic [PW-1:0]   fill_q, fill_d;
	logic [PW-1:0]   pos_q, pos_d;     // current hole / sort index a
	logic [PW-1:0]   jdx_q, jdx_d;     // sort index b
	logic [PW-1:0]   num_q, num_d;     // entries in heap during sift down
	entry_t          cand_q, cand_d;
	logic            last_q, last_d;

	logic            we;
	logic [PW-1:0]   wpos;
	entry_t          wdata;
	logic [PW-1:0]   rpos_a, rpos_b;
	entry_t          rd_a, rd_b;

	logic [PW-1:0]   k_eff;
	logic            wr_cfg;

	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite && (paddr[PADDR_W+1:2] == REG_KEEP_COUNT);
	assign prdata = {{(32-KC_W){1'b0}}, keep_q};

	always_comb begin
		if (keep_q == '0) begin
			k_eff = PW'(1);
		end else if (32'(keep_q) > HEAP_DEPTH) begin
			k_eff = PW'(HEAP_DEPTH);
		end else begin
			k_eff = PW'(keep_q);
		end
	end

	btk_heap_mem #(.DEPTH(HEAP_DEPTH), .AW(AW)) u_mem (
		.clk    (clk),
		.we     (we),
		.waddr  (AW'(wpos - PW'(1))),
		.wdata  (wdata),
		.raddr_a(AW'(rpos_a - PW'(1))),
		.raddr_b(AW'(rpos_b - PW'(1))),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			keep_q  <= KC_W'(16);
			fill_q  <= '0;
			pos_q   <= '0;
			jdx_q   <= '0;
			num_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			pos_q   <= pos_d;
			jdx_q   <= jdx_d;
			num_q   <= num_d;
			last_q  <= last_d;
			if (wr_cfg) begin
				keep_q <= pwdata[KC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		cand_q <= cand_d;
	end

	always_comb begin
		logic [PW-1:0] c;
		logic [PW-1:0] parent;
		c      = '0;
		parent = pos_q >> 1;
		state_d = state_q;
		fill_d  = fill_q;
		pos_d   = pos_q;
		jdx_d   = jdx_q;
		num_d   = num_q;
		cand_d  = cand_q;
		last_d  = last_q;
		we      = 1'b0;
		wpos    = pos_q;
		wdata   = cand_q;
		rpos_a  = PW'(1);
		rpos_b  = PW'(1);
		busy    = 1'b1;
		result_valid    = 1'b0;
		result_tuple_id = rd_a.id;
		result_distance = rd_a.key;
		last_result     = 1'b0;

		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cand_d = '{id: tuple_id, key: distance};
					last_d = last_candidate;
					if (fill_q < k_eff) begin
						fill_d  = fill_q + PW'(1);
						pos_d   = fill_q + PW'(1);
						state_d = ST_UP_RD;
					end else begin
						num_d   = fill_q;
						state_d = ST_ROOT_RD;
					end
				end
			end
			ST_UP_RD: begin
				rpos_a = (parent == '0) ? PW'(1) : parent;
				state_d = ST_UP_CMP;
			end
			ST_UP_CMP: begin
				we = 1'b1;
				if (pos_q > PW'(1) && rd_a.key < cand_q.key) begin
					wdata   = rd_a;
					pos_d   = parent;
					state_d = ST_UP_RD;
				end else begin
					state_d = last_q ? ST_SORT_RD : ST_IDLE;
					pos_d   = PW'(1);
					jdx_d   = PW'(2);
				end
			end
			ST_ROOT_RD: begin
				rpos_a  = PW'(1);
				state_d = ST_ROOT_CMP;
			end
			ST_ROOT_CMP: begin
				if (num_q >= PW'(1) && cand_q.key < rd_a.key) begin
					pos_d   = PW'(1);
					state_d = ST_DN_CHK;
				end else begin
					state_d = last_q ? ST_SORT_RD : ST_IDLE;
					pos_d   = PW'(1);
					jdx_d   = PW'(2);
				end
			end
			ST_DN_CHK: begin
				// children of pos at 2pos, 2pos+1
				c = pos_q << 1;
				if (c <= num_q) begin
					rpos_a  = c;
					rpos_b  = (c < num_q) ? c + PW'(1) : c;
					state_d = ST_DN_CMP;
				end else begin
					we      = 1'b1;
					state_d = last_q ? ST_SORT_RD : ST_IDLE;
					pos_d   = PW'(1);
					jdx_d   = PW'(2);
				end
			end
			ST_DN_CMP: begin
				c = pos_q << 1;
				if (c < num_q && rd_b.key > rd_a.key) begin
					c = c + PW'(1);
					wdata = rd_b;
				end else begin
					wdata = rd_a;
				end
				if (cand_q.key >= wdata.key) begin
					wdata   = cand_q;
					we      = 1'b1;
					state_d = last_q ? ST_SORT_RD : ST_IDLE;
					pos_d   = PW'(1);
					jdx_d   = PW'(2);
				end else begin
					we      = 1'b1;
					pos_d   = c;
					state_d = ST_DN_CHK;
				end
			end
			ST_SORT_RD: begin
				if (jdx_q > fill_q) begin
					if (pos_q + PW'(1) >= fill_q) begin
						pos_d   = PW'(1);
						state_d = ST_OUT_RD;
					end else begin
						pos_d = pos_q + PW'(1);
						jdx_d = pos_q + PW'(2);
					end
				end else begin
					rpos_a  = pos_q;
					rpos_b  = jdx_q;
					state_d = ST_SORT_CMP;
				end
			end
			ST_SORT_CMP: begin
				// swap: write j now, i next cycle from cand
				if (rd_b.key < rd_a.key) begin
					we      = 1'b1;
					wpos    = jdx_q;
					wdata   = rd_a;
					cand_d  = rd_b;
					state_d = ST_SORT_WR;
				end else begin
					jdx_d   = jdx_q + PW'(1);
					state_d = ST_SORT_RD;
				end
			end
			ST_SORT_WR: begin
				we      = 1'b1;
				wpos    = pos_q;
				wdata   = cand_q;
				jdx_d   = jdx_q + PW'(1);
				state_d = ST_SORT_RD;
			end
			ST_OUT_RD: begin
				rpos_a  = pos_q;
				state_d = ST_OUT_EMIT;
			end
			ST_OUT_EMIT: begin
				result_valid = 1'b1;
				last_result  = (pos_q == fill_q);
				if (pos_q == fill_q) begin
					fill_d  = '0;
					last_d  = 1'b0;
					state_d = ST_IDLE;
				end else begin
					pos_d   = pos_q + PW'(1);
					state_d = ST_OUT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= PW'(HEAP_DEPTH)) else $error("fill count beyond heap depth");
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result while idle");
	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |=> (fill_q == '0 && !busy))
		else $error("fill not cleared after run");
`endif
endmodule
